[hdl/dmt_pkg.sv]
// Shared types, constants and codes of the DMA range mapping table.
`default_nettype none

package dmt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_PAGES     = 16;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int LEN_W         = $clog2(MAX_PAGES * 4096 + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [63:0] PAGE_BYTES = 64'd4096;
	localparam logic [63:0] PAGE_MASK  = ~(PAGE_BYTES - 64'd1);
	localparam logic [63:0] MAP_LIMIT  = 64'(MAX_PAGES) * PAGE_BYTES;
	localparam logic [63:0] END_LIMIT  = MAP_LIMIT + PAGE_BYTES;
	localparam logic [1:0]  DIR_MAX    = 2'd2;

	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD      = 3'd1;
	localparam logic [2:0] ST_OVERLAP  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] address;
		logic [31:0] length;
		logic [1:0]  direction;
		logic [63:0] owner_id;
		logic        pages_ok;
	} req_t;

	typedef struct packed {
		logic [63:0]      base;
		logic [LEN_W-1:0] length;
		logic [1:0]       direction;
		logic [63:0]      owner;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_entry;
		logic             clr_en;
		logic [IDX_W-1:0] clr_idx;
	} cmd_t;

	typedef struct packed {
		logic             overlap;
		logic             hit_found;
		logic [IDX_W-1:0] hit_idx;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
	} scan_t;

endpackage

`default_nettype wire

[hdl/dmt_if.sv]
// Request and response channel interfaces of the DMA range mapping table.
`default_nettype none

interface dmt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] address;
	logic [31:0] length;
	logic [1:0]  direction;
	logic [63:0] owner_id;
	logic        pages_ok;

	modport source (
		output valid, operation, address, length, direction, owner_id, pages_ok,
		input  ready
	);
	modport sink (
		input  valid, operation, address, length, direction, owner_id, pages_ok,
		output ready
	);
endinterface

interface dmt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] device_address;
	logic        is_mapped;

	modport source (
		output valid, status, device_address, is_mapped,
		input  ready
	);
	modport sink (
		input  valid, status, device_address, is_mapped,
		output ready
	);
endinterface

`default_nettype wire

[hdl/dmt_engine.sv]
// Table memory, valid bits and the per-entry scan compare with its accumulators.
`default_nettype none

module dmt_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dmt_pkg::cmd_t cmd,
	input  wire dmt_pkg::req_t req,
	input  wire logic [64:0]   qend,
	output dmt_pkg::scan_t     scan
);

	dmt_pkg::entry_t mem [dmt_pkg::TABLE_ENTRIES];

	logic [dmt_pkg::TABLE_ENTRIES-1:0] valid_q;

	logic                      act_s1;
	logic                      vld_s1;
	logic [dmt_pkg::IDX_W-1:0] idx_s1;
	dmt_pkg::entry_t           ent_s1;

	logic [64:0] slot_end;
	logic        meet;
	logic        hit;

	dmt_pkg::scan_t acc_q;

	// Table storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_idx] <= cmd.wr_entry;
		end
		if (cmd.rd_en) begin
			ent_s1 <= mem[cmd.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[cmd.wr_idx] <= 1'b1;
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[cmd.rd_idx];
		idx_s1 <= cmd.rd_idx;
	end

	// A wrapping request range meets every valid entry.
	always_comb begin
		slot_end = {1'b0, ent_s1.base} + 65'(ent_s1.length);
		meet     = (|req.length) &&
			(qend[64] || (({1'b0, ent_s1.base} < qend) && ({1'b0, req.address} < slot_end)));
		hit      = (ent_s1.base == req.address) && (32'(ent_s1.length) == req.length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.start) begin
			acc_q <= '0;
		end else if (act_s1) begin
			if (vld_s1 && meet) begin
				acc_q.overlap <= 1'b1;
			end
			if (!acc_q.hit_found && vld_s1 && hit) begin
				acc_q.hit_found <= 1'b1;
				acc_q.hit_idx   <= idx_s1;
			end
			if (!acc_q.free_found && !vld_s1) begin
				acc_q.free_found <= 1'b1;
				acc_q.free_idx   <= idx_s1;
			end
		end
	end

	assign scan = acc_q;

endmodule

`default_nettype wire

[hdl/dmt_ctrl.sv]
// Request sequencer: scan control, argument checks, result and table update.
`default_nettype none

module dmt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	dmt_req_if.sink             req,
	dmt_rsp_if.source           rsp,
	input  wire dmt_pkg::scan_t scan,
	output dmt_pkg::cmd_t       cmd,
	output dmt_pkg::req_t       req_s,
	output logic [64:0]         qend_s
);

	dmt_pkg::state_t state_q, state_d;

	dmt_pkg::req_t             req_q;
	logic [64:0]               qend_q;
	logic [63:0]               endpg_q;
	logic [dmt_pkg::IDX_W-1:0] cnt_q;

	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [63:0] rsp_dev_q;
	logic        rsp_mapped_q;

	logic        accept;
	logic        out_free;
	logic        finish;
	logic        args_ok;
	logic [63:0] start_pg;
	logic [2:0]  res_status;
	logic [63:0] res_dev;
	logic        res_mapped;
	logic        do_map;
	logic        do_unmap;

	assign req.ready = (state_q == dmt_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == dmt_pkg::S_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dmt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = dmt_pkg::S_SCAN;
				end
			end
			dmt_pkg::S_SCAN: begin
				if (cnt_q == dmt_pkg::LAST_IDX) begin
					state_d = dmt_pkg::S_DRAIN;
				end
			end
			dmt_pkg::S_DRAIN: begin
				state_d = dmt_pkg::S_FINISH;
			end
			dmt_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = dmt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dmt_pkg::S_IDLE;
			end
		endcase
	end

	// Map argument checks; endpg_q is the page-rounded end, settled during the scan.
	always_comb begin
		start_pg = req_q.address & dmt_pkg::PAGE_MASK;
		args_ok  = (|req_q.length) && (|req_q.owner_id) &&
			(req_q.direction <= dmt_pkg::DIR_MAX) && !qend_q[64] &&
			({32'd0, req_q.length} <= dmt_pkg::MAP_LIMIT) &&
			!(endpg_q < start_pg) &&
			((endpg_q - req_q.address) <= dmt_pkg::END_LIMIT) &&
			req_q.pages_ok;
	end

	always_comb begin
		res_status = dmt_pkg::ST_BAD;
		res_dev    = '0;
		res_mapped = 1'b0;
		do_map     = 1'b0;
		do_unmap   = 1'b0;
		case (req_q.operation)
			dmt_pkg::OP_MAP: begin
				if (!args_ok) begin
					res_status = dmt_pkg::ST_BAD;
				end else if (scan.overlap) begin
					res_status = dmt_pkg::ST_OVERLAP;
				end else if (!scan.free_found) begin
					res_status = dmt_pkg::ST_FULL;
				end else begin
					res_status = dmt_pkg::ST_OK;
					res_dev    = req_q.address;
					do_map     = 1'b1;
				end
			end
			dmt_pkg::OP_UNMAP: begin
				if (!(|req_q.length)) begin
					res_status = dmt_pkg::ST_BAD;
				end else if (scan.hit_found) begin
					res_status = dmt_pkg::ST_OK;
					do_unmap   = 1'b1;
				end else begin
					res_status = dmt_pkg::ST_NOTFOUND;
				end
			end
			dmt_pkg::OP_QUERY: begin
				res_status = dmt_pkg::ST_OK;
				res_mapped = scan.overlap;
			end
			default: begin
				res_status = dmt_pkg::ST_BAD;
			end
		endcase
	end

	always_comb begin
		cmd                    = '0;
		cmd.start              = accept;
		cmd.rd_en              = (state_q == dmt_pkg::S_SCAN);
		cmd.rd_idx             = cnt_q;
		cmd.wr_en              = finish && do_map;
		cmd.wr_idx             = scan.free_idx;
		cmd.wr_entry.base      = req_q.address;
		cmd.wr_entry.length    = req_q.length[dmt_pkg::LEN_W-1:0];
		cmd.wr_entry.direction = req_q.direction;
		cmd.wr_entry.owner     = req_q.owner_id;
		cmd.clr_en             = finish && do_unmap;
		cmd.clr_idx            = scan.hit_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmt_pkg::S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == dmt_pkg::S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.operation <= req.operation;
			req_q.address   <= req.address;
			req_q.length    <= req.length;
			req_q.direction <= req.direction;
			req_q.owner_id  <= req.owner_id;
			req_q.pages_ok  <= req.pages_ok;
			qend_q          <= {1'b0, req.address} + {33'd0, req.length};
		end
		if (state_q == dmt_pkg::S_SCAN) begin
			endpg_q <= (qend_q[63:0] + (dmt_pkg::PAGE_BYTES - 64'd1)) & dmt_pkg::PAGE_MASK;
		end
		if (finish) begin
			rsp_status_q <= res_status;
			rsp_dev_q    <= res_dev;
			rsp_mapped_q <= res_mapped;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.device_address = rsp_dev_q;
	assign rsp.is_mapped      = rsp_mapped_q;

	assign req_s  = req_q;
	assign qend_s = qend_q;

endmodule

`default_nettype wire

[hdl/dma_range_mapping_table_top.sv]
// Top level of the DMA range mapping table.
`default_nettype none

// DMA range mapping table. Each request on req is one of map, unmap or query
// and produces exactly one response on rsp. The table holds TABLE_ENTRIES
// slots (64) in a single-port-read, single-port-write memory; a valid bit per
// slot sits in flip-flops that reset clears at once, so the block is ready
// right after reset with no clearing pass. Every request walks the whole
// table through the memory read port, one slot per cycle: the scan state
// reads each slot in turn, the drain state waits for the last read to
// return, and the finish state decides, updates the table and loads the
// response register; the next request is accepted in the idle state that
// follows. Requests are handled one at a time; the table update of a
// request lands before the scan of the next one starts, so no forwarding
// is needed. A response that the consumer has not yet taken holds in the
// output register while the next request is accepted and scanned; the
// decision cycle waits only if that response is still pending when the
// new one is ready. Map checks its arguments (nonzero length and owner,
// direction at most 2, no address wrap, length within MAX_PAGES pages and
// page-rounded span within MAX_PAGES + 1 pages, pages_ok set), then rejects
// any overlap with a valid slot, then writes the lowest free slot and
// returns the base as device_address. Unmap clears the lowest valid slot
// with equal base and length. Query returns is_mapped when the range
// overlaps any valid slot; a range that wraps overlaps all.

module dma_range_mapping_table_top (
	input  wire logic clk,
	input  wire logic arst_n,
	dmt_req_if.sink   req,
	dmt_rsp_if.source rsp
);

	dmt_pkg::cmd_t  cmd;
	dmt_pkg::scan_t scan;
	dmt_pkg::req_t  req_s;
	logic [64:0]    qend_s;

	// Sequence the scan, decide the result, issue the table update.
	dmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.scan   (scan),
		.cmd    (cmd),
		.req_s  (req_s),
		.qend_s (qend_s)
	);

	// Hold the table and compare each slot against the held request.
	dmt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req_s),
		.qend   (qend_s),
		.scan   (scan)
	);

endmodule

`default_nettype wire

[hdl/dmt_checker.sv]
// Port-level checks of the DMA range mapping table and their binding.
`default_nettype none

module dmt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  rsp_status,
	input wire logic [63:0] rsp_device_address,
	input wire logic        rsp_is_mapped
);

	// Requests are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == dmt_pkg::ST_OK || rsp_status == dmt_pkg::ST_BAD ||
			rsp_status == dmt_pkg::ST_OVERLAP || rsp_status == dmt_pkg::ST_FULL ||
			rsp_status == dmt_pkg::ST_NOTFOUND))
		else $error("undefined status code");

	a_dev_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != dmt_pkg::ST_OK) |-> (rsp_device_address == 64'd0))
		else $error("device address on a failed request");

	a_mapped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_mapped |-> (rsp_status == dmt_pkg::ST_OK) &&
			(rsp_device_address == 64'd0))
		else $error("is_mapped set outside a query");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("stalled response dropped or changed");

endmodule

bind dma_range_mapping_table_top dmt_checker u_dmt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_device_address (rsp.device_address),
	.rsp_is_mapped      (rsp.is_mapped)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench for the DMA range mapping table: directed and random requests checked against a predictor.
`default_nettype none

module testbench;

	localparam logic [1:0]  OP_UNDEFINED = 2'd3;
	localparam int          MAX_WAIT     = 17;
	localparam int          DRAIN_CYCLES = dmt_pkg::TABLE_ENTRIES + 16;
	localparam int          RANDOM_ITEMS = 1600;
	localparam int          WINDOW_SPAN  = 2**21 - 1;
	localparam logic [63:0] TOP_WINDOW   = 64'hFFFF_FFFF_FFE0_0000;
	localparam logic [63:0] FILL_BASE    = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] device_address;
		logic        is_mapped;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dmt_req_if req_ch();
	dmt_rsp_if rsp_ch();

	dma_range_mapping_table_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #2 clk = ~clk;

	// Shadow copy of the table, updated when a request is accepted.
	logic                      slot_live  [dmt_pkg::TABLE_ENTRIES];
	logic [63:0]               slot_start [dmt_pkg::TABLE_ENTRIES];
	logic [dmt_pkg::LEN_W-1:0] slot_size  [dmt_pkg::TABLE_ENTRIES];
	logic [1:0]                slot_dir   [dmt_pkg::TABLE_ENTRIES];
	logic [63:0]               slot_tag   [dmt_pkg::TABLE_ENTRIES];

	table_result_t expected_results[$];

	int          error_count   = 0;
	int          sent_count    = 0;
	int          checked_count = 0;
	int          op_count[4]     = '{default: 0};
	int          status_count[8] = '{default: 0};
	int          send_calm = 0;
	int          take_calm = 0;
	logic [63:0] low_window = 64'd0;

	function automatic logic spans_meet(input logic [63:0] a, input logic [63:0] a_len,
			input logic [63:0] b, input logic [63:0] b_len);
		logic [64:0] a_end;
		logic [64:0] b_end;
		a_end = {1'b0, a} + {1'b0, a_len};
		b_end = {1'b0, b} + {1'b0, b_len};
		if (a_len == 64'd0 || b_len == 64'd0)
			return 1'b0;
		// a range running past the top of the address space meets everything
		if (a_end[64] || b_end[64])
			return 1'b1;
		return (a < b_end[63:0]) && (b < a_end[63:0]);
	endfunction

	function automatic logic range_taken(input logic [63:0] base, input logic [63:0] len);
		for (int i = 0; i < dmt_pkg::TABLE_ENTRIES; i++) begin
			if (slot_live[i] && spans_meet(slot_start[i], 64'(slot_size[i]), base, len))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic map_args_legal(input dmt_pkg::req_t r);
		logic [63:0] len;
		logic [64:0] tail;
		logic [63:0] first_page;
		logic [63:0] last_page;
		len        = 64'(r.length);
		tail       = {1'b0, r.address} + {1'b0, len};
		first_page = r.address & dmt_pkg::PAGE_MASK;
		last_page  = (r.address + len + (dmt_pkg::PAGE_BYTES - 64'd1)) & dmt_pkg::PAGE_MASK;
		if (len == 64'd0 || r.owner_id == 64'd0 || r.direction > dmt_pkg::DIR_MAX)
			return 1'b0;
		if (tail[64] || len > dmt_pkg::MAP_LIMIT)
			return 1'b0;
		if (last_page < first_page || last_page - r.address > dmt_pkg::END_LIMIT)
			return 1'b0;
		return r.pages_ok;
	endfunction

	// Work out the response of one request and update the shadow table.
	function automatic table_result_t apply_request(input dmt_pkg::req_t r);
		table_result_t res;
		logic [63:0]   len;
		logic          placed;
		len                = 64'(r.length);
		res.status         = dmt_pkg::ST_BAD;
		res.device_address = 64'd0;
		res.is_mapped      = 1'b0;
		placed             = 1'b0;
		case (r.operation)
			dmt_pkg::OP_MAP: begin
				if (!map_args_legal(r)) begin
					res.status = dmt_pkg::ST_BAD;
				end else if (range_taken(r.address, len)) begin
					res.status = dmt_pkg::ST_OVERLAP;
				end else begin
					res.status = dmt_pkg::ST_FULL;
					for (int i = 0; i < dmt_pkg::TABLE_ENTRIES; i++) begin
						if (!slot_live[i] && !placed) begin
							slot_live[i]       = 1'b1;
							slot_start[i]      = r.address;
							slot_size[i]       = r.length[dmt_pkg::LEN_W-1:0];
							slot_dir[i]        = r.direction;
							slot_tag[i]        = r.owner_id;
							placed             = 1'b1;
							res.status         = dmt_pkg::ST_OK;
							res.device_address = r.address;
						end
					end
				end
			end
			dmt_pkg::OP_UNMAP: begin
				if (len == 64'd0) begin
					res.status = dmt_pkg::ST_BAD;
				end else begin
					res.status = dmt_pkg::ST_NOTFOUND;
					for (int i = 0; i < dmt_pkg::TABLE_ENTRIES; i++) begin
						if (slot_live[i] && !placed && slot_start[i] == r.address &&
								64'(slot_size[i]) == len) begin
							slot_live[i]  = 1'b0;
							slot_start[i] = 64'd0;
							slot_size[i]  = '0;
							slot_tag[i]   = 64'd0;
							placed        = 1'b1;
							res.status    = dmt_pkg::ST_OK;
						end
					end
				end
			end
			dmt_pkg::OP_QUERY: begin
				res.status    = dmt_pkg::ST_OK;
				res.is_mapped = range_taken(r.address, len);
			end
			default: res.status = dmt_pkg::ST_BAD;
		endcase
		return res;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < dmt_pkg::TABLE_ENTRIES; i++)
			n += slot_live[i];
		return n;
	endfunction

	function automatic int pick_live_slot();
		int first;
		int idx;
		first = $urandom_range(0, dmt_pkg::TABLE_ENTRIES - 1);
		for (int k = 0; k < dmt_pkg::TABLE_ENTRIES; k++) begin
			idx = (first + k) % dmt_pkg::TABLE_ENTRIES;
			if (slot_live[idx])
				return idx;
		end
		return -1;
	endfunction

	// Random wait in cycles, with occasional runs of back-to-back traffic.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic dmt_pkg::req_t make_request(input logic [1:0] op,
			input logic [63:0] addr, input logic [31:0] len, input logic [1:0] dir,
			input logic [63:0] owner, input logic pok);
		dmt_pkg::req_t r;
		r.operation = op;
		r.address   = addr;
		r.length    = len;
		r.direction = dir;
		r.owner_id  = owner;
		r.pages_ok  = pok;
		return r;
	endfunction

	function automatic logic [63:0] pick_address();
		logic [63:0] a;
		case ($urandom_range(0, 9))
			0:       a = {$urandom, $urandom};
			1, 2:    a = TOP_WINDOW + 64'($urandom_range(0, WINDOW_SPAN));
			default: a = low_window + 64'($urandom_range(0, WINDOW_SPAN));
		endcase
		if ($urandom_range(0, 1) == 0)
			a = a & dmt_pkg::PAGE_MASK;
		return a;
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 31))
			0:                   return 32'd0;
			1:                   return $urandom;
			2:                   return 32'(dmt_pkg::MAP_LIMIT) + 32'($urandom_range(0, 1));
			3, 4, 5, 6, 7, 8, 9: return 32'($urandom_range(1, 65536));
			default:             return 32'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic dmt_pkg::req_t random_request();
		dmt_pkg::req_t r;
		int            pick;
		int            slot;
		pick        = $urandom_range(0, 99);
		slot        = pick_live_slot();
		r.address   = pick_address();
		r.length    = pick_length();
		r.direction = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		r.owner_id  = ($urandom_range(0, 31) == 0) ? 64'd0 : {$urandom, $urandom};
		r.pages_ok  = ($urandom_range(0, 15) != 0);
		if (pick < 2) begin
			r.operation = OP_UNDEFINED;
		end else if (pick < ((live_count() > 60) ? 30 : 55)) begin
			r.operation = dmt_pkg::OP_MAP;
		end else if (pick < 80) begin
			r.operation = dmt_pkg::OP_UNMAP;
			// mostly hit a live entry; sometimes miss by length only
			if (slot >= 0 && $urandom_range(0, 3) != 0) begin
				r.address = slot_start[slot];
				r.length  = 32'(slot_size[slot]);
				case ($urandom_range(0, 7))
					0:       r.length = r.length + 32'd1;
					1:       r.length = r.length | 32'h0002_0000;
					default: ;
				endcase
			end
		end else begin
			r.operation = dmt_pkg::OP_QUERY;
			if (slot >= 0 && $urandom_range(0, 1) == 0)
				r.address = slot_start[slot] + 64'($urandom_range(0, 65535)) - 64'h8000;
		end
		return r;
	endfunction

	// Present one request after a random gap and hold it until accepted.
	task automatic send_request(input dmt_pkg::req_t r);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= r.operation;
		req_ch.address   <= r.address;
		req_ch.length    <= r.length;
		req_ch.direction <= r.direction;
		req_ch.owner_id  <= r.owner_id;
		req_ch.pages_ok  <= r.pages_ok;
		do @(posedge clk); while (!req_ch.ready);
		expected_results.push_back(apply_request(r));
		op_count[r.operation]++;
		sent_count++;
	endtask

	// Every argument check on map, one at a time.
	task automatic test_map_rejects();
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'd0, 2'd0, 64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'h100, 2'd0, 64'd0, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'h100, 2'd3, 64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'hFFFF_FFFF_FFFF_FF00, 32'h200, 2'd0,
			64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'(dmt_pkg::MAP_LIMIT) + 32'd1,
			2'd0, 64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'hFFFF_FFFF_FFFF_F000, 32'h800, 2'd0,
			64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'h100, 2'd0, 64'd1, 1'b0));
		send_request(make_request(dmt_pkg::OP_MAP, 64'd0, 32'hFFFF_FFFF, 2'd0, 64'd1, 1'b1));
	endtask

	// Map, overlap, query and unmap basics, with the field extremes.
	task automatic test_map_unmap_query();
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1000, 32'h1000, 2'd0, 64'd1, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'hFFFF_FFFF_FFFE_0000,
			32'(dmt_pkg::MAP_LIMIT), 2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h1800, 32'h10, 2'd1, 64'd2, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, 64'h2000, 32'd1, 2'd1, 64'd3, 1'b1));
		send_request(make_request(dmt_pkg::OP_QUERY, 64'h1FFF, 32'd1, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_QUERY, 64'h2001, 32'hFFF, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_QUERY, 64'h1000, 32'd0, 2'd0, 64'd0, 1'b0));
		// a wrapping query range meets every live entry
		send_request(make_request(dmt_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 2'd3,
			64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_MAP, 64'd0, 32'h1000, 2'd0, 64'd4, 1'b1));
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'h1000, 32'd0, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'h1000, 32'h1001, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'h1000, 32'h1000, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'h1000, 32'h1000, 2'd0, 64'd0, 1'b0));
		send_request(make_request(OP_UNDEFINED, 64'h2000, 32'd1, 2'd1, 64'd5, 1'b1));
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'hFFFF_FFFF_FFFE_0000,
			32'(dmt_pkg::MAP_LIMIT), 2'd0, 64'd0, 1'b0));
		// length bits above the stored width must still take part in the match
		send_request(make_request(dmt_pkg::OP_UNMAP, 64'h2000, 32'h0002_0001, 2'd0, 64'd0,
			1'b0));
	endtask

	// Fill every free slot, probe the full table, then drain it again.
	task automatic test_table_full();
		int filled;
		filled = 0;
		while (live_count() < dmt_pkg::TABLE_ENTRIES) begin
			send_request(make_request(dmt_pkg::OP_MAP, FILL_BASE + 64'(filled) * 64'h2000,
				32'h1000, 2'($urandom_range(0, 2)), 64'(filled + 1), 1'b1));
			filled++;
		end
		send_request(make_request(dmt_pkg::OP_MAP, FILL_BASE + 64'(filled) * 64'h2000,
			32'h1000, 2'd0, 64'd7, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, FILL_BASE, 32'h10, 2'd0, 64'd7, 1'b1));
		send_request(make_request(dmt_pkg::OP_MAP, FILL_BASE, 32'd0, 2'd0, 64'd7, 1'b1));
		send_request(make_request(dmt_pkg::OP_QUERY, FILL_BASE + 64'h1000, 32'h1000, 2'd0,
			64'd0, 1'b0));
		for (int k = 0; k < filled; k++)
			send_request(make_request(dmt_pkg::OP_UNMAP, FILL_BASE + 64'(k) * 64'h2000,
				32'h1000, 2'd0, 64'd0, 1'b0));
		send_request(make_request(dmt_pkg::OP_UNMAP, FILL_BASE, 32'h1000, 2'd0, 64'd0, 1'b0));
	endtask

	task automatic test_random_traffic(input int count);
		for (int n = 0; n < count; n++) begin
			// move the dense window now and then so stale entries pile up elsewhere
			if (n % 400 == 0)
				low_window = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom, $urandom};
			send_request(random_request());
		end
	endtask

	// Response side: stall at random, then take the next response.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Compare each accepted response with the oldest prediction.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected response: status %0d, device_address %h, is_mapped %0d",
					rsp_ch.status, rsp_ch.device_address, rsp_ch.is_mapped);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				status_count[want.status]++;
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.device_address !== want.device_address) begin
					$error("device_address: expected %h, actual %h", want.device_address,
						rsp_ch.device_address);
					error_count++;
				end
				if (rsp_ch.is_mapped !== want.is_mapped) begin
					$error("is_mapped: expected %0d, actual %0d", want.is_mapped,
						rsp_ch.is_mapped);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= dmt_pkg::OP_MAP;
		req_ch.address   <= 64'd0;
		req_ch.length    <= 32'd0;
		req_ch.direction <= 2'd0;
		req_ch.owner_id  <= 64'd0;
		req_ch.pages_ok  <= 1'b0;
		for (int i = 0; i < dmt_pkg::TABLE_ENTRIES; i++) begin
			slot_live[i]  = 1'b0;
			slot_start[i] = 64'd0;
			slot_size[i]  = '0;
			slot_dir[i]   = 2'd0;
			slot_tag[i]   = 64'd0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_map_rejects();
		test_map_unmap_query();
		test_table_full();
		test_random_traffic(RANDOM_ITEMS);
		req_ch.valid <= 1'b0;

		// wait out the outstanding responses, then watch for strays
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d map, %0d unmap, %0d query, %0d undefined op; %0d checked.",
			sent_count, op_count[dmt_pkg::OP_MAP], op_count[dmt_pkg::OP_UNMAP],
			op_count[dmt_pkg::OP_QUERY], op_count[OP_UNDEFINED], checked_count);
		$display("Responses seen: ok %0d, bad args %0d, overlap %0d, full %0d, not found %0d.",
			status_count[dmt_pkg::ST_OK], status_count[dmt_pkg::ST_BAD],
			status_count[dmt_pkg::ST_OVERLAP], status_count[dmt_pkg::ST_FULL],
			status_count[dmt_pkg::ST_NOTFOUND]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hdl/dmt_pkg.sv
hdl/dmt_if.sv
hdl/dmt_engine.sv
hdl/dmt_ctrl.sv
hdl/dma_range_mapping_table_top.sv
hdl/dmt_checker.sv
sim/testbench.sv
